// ===== sv/nhht_pkg.sv =====
// ----------------------------------------------------------------------------
// nhht_pkg: shared types for the next-hop hash table
// Node ID width, the stored entry layout and the controller/datapath link.
// ----------------------------------------------------------------------------
package nhht_pkg;

    localparam int ID_W = 8;

    typedef struct packed {
        logic [ID_W-1:0] dest;
        logic [ID_W-1:0] next;
    } t_entry;

    // Commands from controller to datapath, one step per cycle.
    typedef struct packed {
        logic accept;     // capture the request beat
        logic hash_quot;  // dest / SLOTS by reciprocal multiply
        logic hash_rem;   // bucket = dest - quot * SLOTS
        logic load_base;  // bucket base address and fill count
        logic scan;       // issue the next way read of the chain
        logic finish;     // write back and load the response
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_done;  // match found or chain fully compared
        logic out_free;   // response register can take a new beat
    } t_status;

endpackage

// ===== sv/nhht_req_if.sv =====
// ----------------------------------------------------------------------------
// nhht_req_if: request channel of the next-hop hash table
// Carries one lookup or set per beat.
// ----------------------------------------------------------------------------
interface nhht_req_if
    import nhht_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            mode;
    logic [ID_W-1:0] dest_id;
    logic [ID_W-1:0] next_hop_in;

    modport source (output valid, mode, dest_id, next_hop_in, input ready);
    modport sink   (input valid, mode, dest_id, next_hop_in, output ready);
endinterface

// ===== sv/nhht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nhht_rsp_if: response channel of the next-hop hash table
// Carries one result per beat.
// ----------------------------------------------------------------------------
interface nhht_rsp_if
    import nhht_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            hit;
    logic [ID_W-1:0] next_hop;
    logic            overflow;

    modport source (output valid, hit, next_hop, overflow, input ready);
    modport sink   (input valid, hit, next_hop, overflow, output ready);
endinterface

// ===== sv/next_hop_hash_table.sv =====
// ----------------------------------------------------------------------------
// next_hop_hash_table: routing table from destination ID to next-hop ID
// Hash table with SLOTS buckets, each a chain of at most WAYS entries.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one beat per operation: mode 0 looks up dest_id, mode 1
//   sets next_hop_in for dest_id (update on match, append otherwise; a full
//   bucket without a match reports overflow and changes nothing).
//   o_rsp returns exactly one beat per request: hit, next_hop (lookup hit
//   only, else 0) and overflow, in request order.
//   The bucket is dest_id mod SLOTS, found by a reciprocal multiply and
//   a remainder step. The chain is then read from the single-port entry
//   memory one way per cycle, stopping at the first match or at the
//   bucket's fill count. Each request runs through hash, base load, chain
//   scan and write back, where the response register is loaded; a new
//   request is taken only after write back, when the sequencer is idle
//   again, so requests do not overlap.
//   Reset clears all bucket fill counts at once, so the table starts empty
//   with no sweep; the entry memory itself is not cleared.
//   A stalled receiver holds the response in its register; the next request
//   can be taken and worked on, and it waits at write back until the
//   response register frees.
// ----------------------------------------------------------------------------
module next_hop_hash_table
    import nhht_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int WAYS  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nhht_req_if.sink   i_req,
    nhht_rsp_if.source o_rsp
);

    t_cmd    cmd;
    t_status status;

    // Sequence each request through its steps.
    nhht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Hash, scan the chain, write back and hold the response.
    nhht_datapath #(
        .SLOTS (SLOTS),
        .WAYS  (WAYS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_mode        (i_req.mode),
        .i_dest_id     (i_req.dest_id),
        .i_next_hop_in (i_req.next_hop_in),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_hit         (o_rsp.hit),
        .o_next_hop    (o_rsp.next_hop),
        .o_overflow    (o_rsp.overflow)
    );

endmodule

// ===== sv/nhht_ctrl.sv =====
// ----------------------------------------------------------------------------
// nhht_ctrl: sequencer of the next-hop hash table
// Steps one request through hash, chain scan and write back.
// ----------------------------------------------------------------------------
module nhht_ctrl
    import nhht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUOT,
        S_REM,
        S_BASE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req_valid && r_in_ready) n_state = S_QUOT;
            S_QUOT: n_state = S_REM;
            S_REM:  n_state = S_BASE;
            S_BASE: n_state = S_SCAN;
            S_SCAN: if (i_status.scan_done) n_state = S_FIN;
            S_FIN:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_req_valid && r_in_ready;
        o_cmd.hash_quot = (r_state == S_QUOT);
        o_cmd.hash_rem  = (r_state == S_REM);
        o_cmd.load_base = (r_state == S_BASE);
        o_cmd.scan      = (r_state == S_SCAN);
        o_cmd.finish    = (r_state == S_FIN) && i_status.out_free;
    end

    assign o_req_ready = r_in_ready;

endmodule

// ===== sv/nhht_datapath.sv =====
// ----------------------------------------------------------------------------
// nhht_datapath: hashing, entry memory and response register
// Holds the chained entries, per-bucket fill counts and the compare logic.
// ----------------------------------------------------------------------------
module nhht_datapath
    import nhht_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int WAYS  = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    input  logic            i_mode,
    input  logic [ID_W-1:0] i_dest_id,
    input  logic [ID_W-1:0] i_next_hop_in,
    input  logic            i_rsp_ready,
    output logic            o_rsp_valid,
    output logic            o_hit,
    output logic [ID_W-1:0] o_next_hop,
    output logic            o_overflow
);

    localparam int DEPTH  = SLOTS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BKT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    // floor(2^16 / SLOTS) + 1 gives an exact quotient for any 8-bit key
    localparam int RECIP  = 65536 / SLOTS + 1;
    localparam int PROD_W = ID_W + 17;

    t_entry            mem [DEPTH];
    logic [FILL_W-1:0] r_fill_cnt [SLOTS];

    logic              r_mode;
    logic [ID_W-1:0]   r_dest;
    logic [ID_W-1:0]   r_nh;
    logic [ID_W-1:0]   r_quot;
    logic [BKT_W-1:0]  r_bucket;
    logic [ADDR_W-1:0] r_base;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_way;
    logic              r_rd_vld;
    logic [WAY_W-1:0]  r_rd_way;
    t_entry            r_rd_data;
    logic              r_found;
    logic [WAY_W-1:0]  r_match_way;
    logic [ID_W-1:0]   r_match_next;
    logic              r_out_valid;
    logic              r_hit;
    logic [ID_W-1:0]   r_next_hop;
    logic              r_overflow;

    logic [PROD_W-1:0] quot_prod;
    logic [16:0]       quot_sl;
    logic [16:0]       rem_full;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              wr_append;
    logic [ADDR_W-1:0] wr_addr;
    logic              bucket_full;

    assign quot_prod = PROD_W'(r_dest) * PROD_W'(RECIP);
    assign quot_sl   = 17'(r_quot) * 17'(SLOTS);
    assign rem_full  = 17'(r_dest) - quot_sl;

    assign rd_en   = i_cmd.scan && (r_way < r_fill) && !r_found;
    assign rd_addr = r_base + ADDR_W'(r_way);

    assign bucket_full = (r_fill == FILL_W'(WAYS));
    assign wr_append   = i_cmd.finish && r_mode && !r_found && !bucket_full;
    assign wr_en       = (i_cmd.finish && r_mode && r_found) || wr_append;
    assign wr_addr     = r_found ? r_base + ADDR_W'(r_match_way)
                                 : r_base + ADDR_W'(r_fill);

    assign o_status.scan_done = r_found || ((r_way == r_fill) && !r_rd_vld);
    assign o_status.out_free  = !r_out_valid || i_rsp_ready;

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{dest: r_dest, next: r_nh};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Request capture, hashing, chain compare and response load.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_dest <= i_dest_id;
            r_nh   <= i_next_hop_in;
        end
        if (i_cmd.hash_quot) begin
            r_quot <= quot_prod[16 +: ID_W];
        end
        if (i_cmd.hash_rem) begin
            r_bucket <= rem_full[BKT_W-1:0];
        end
        if (i_cmd.load_base) begin
            r_base <= ADDR_W'(32'(r_bucket) * 32'(WAYS));
            r_fill <= r_fill_cnt[r_bucket];
        end
        if (rd_en) begin
            r_rd_way <= r_way[WAY_W-1:0];
        end
        if (r_rd_vld && !r_found && (r_rd_data.dest == r_dest)) begin
            r_match_way  <= r_rd_way;
            r_match_next <= r_rd_data.next;
        end
        if (i_cmd.finish) begin
            r_hit      <= r_found;
            r_next_hop <= (!r_mode && r_found) ? r_match_next : '0;
            r_overflow <= r_mode && !r_found && bucket_full;
        end
    end

    // Control state: scan progress, fill counts, response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_fill_cnt[s] <= '0;
            end
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.load_base) begin
                r_way   <= '0;
                r_found <= 1'b0;
            end else if (rd_en) begin
                r_way <= r_way + FILL_W'(1);
            end
            if (r_rd_vld && !r_found && (r_rd_data.dest == r_dest)) begin
                r_found <= 1'b1;
            end
            if (wr_append) begin
                r_fill_cnt[r_bucket] <= r_fill + FILL_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_next_hop  = r_next_hop;
    assign o_overflow  = r_overflow;

endmodule
